// ===== hdl/sbm_pkg.sv =====
`default_nettype none

package sbm_pkg;

  localparam int COMP_W     = 24;
  localparam int SQ_W       = 2 * COMP_W;
  localparam int RAD_W      = 64;
  localparam int MAG_W      = 32;
  localparam int REM_W      = MAG_W + 3;
  localparam int NORM_W     = MAG_W + 1;
  localparam int EXP_W      = 6;
  localparam int MANT_W     = 31;
  localparam int LPROD_W    = 2 * MANT_W;
  localparam int LOG_BITS   = 20;
  localparam int LOGI_W     = 5;
  localparam int LOG_W      = LOGI_W + LOG_BITS;
  localparam int K_W        = 27;
  localparam int DBPROD_W   = LOG_W + K_W;
  localparam int SUM_W      = 44;
  localparam int ROOT_STEPS = MAG_W;
  localparam int CNT_W      = 5;

  // 20*log10(2) in Q.24
  localparam logic [K_W-1:0]      DB_PER_OCTAVE = 27'd101008905;
  localparam logic [DBPROD_W:0]   DB_ROUND      = 53'd34359738368;
  localparam logic [NORM_W-1:0]   ONE_Q8        = 33'd256;
  localparam logic [EXP_W-1:0]    EXP_TOP       = 6'd32;
  localparam logic [EXP_W-1:0]    EXP_BIAS      = 6'd8;

  typedef struct packed {
    logic capture;
    logic mul_re;
    logic mul_im;
    logic rad_ld;
    logic root_step;
    logic norm_ld;
    logic norm_shift;
    logic sq_mul;
    logic sq_first;
    logic frac_shift;
    logic db_mul;
    logic db_rnd;
    logic emit;
  } sbm_cmd_t;

  typedef struct packed {
    logic out_free;
    logic db_mode;
    logic norm_top;
  } sbm_sts_t;

endpackage

`default_nettype wire

// ===== hdl/sbm_if.sv =====
`default_nettype none

interface sbm_in_if;
  import sbm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] re_part;
  logic signed [COMP_W-1:0] im_part;
  logic                     frame_end;

  modport source (output valid, output re_part, output im_part, output frame_end,
                  input ready);
  modport sink (input valid, input re_part, input im_part, input frame_end,
                output ready);
endinterface

interface sbm_out_if;
  import sbm_pkg::*;

  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] bin_value;
  logic [MAG_W-1:0] peak_value;
  logic [SUM_W-1:0] value_sum;
  logic             frame_done;

  modport source (output valid, output bin_value, output peak_value, output value_sum,
                  output frame_done, input ready);
  modport sink (input valid, input bin_value, input peak_value, input value_sum,
                input frame_done, output ready);
endinterface

`default_nettype wire

// ===== hdl/sbm_ctrl.sv =====
`default_nettype none

module sbm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sbm_pkg::sbm_sts_t sts,
  output sbm_pkg::sbm_cmd_t cmd
);
  import sbm_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_SQ_RE   = 11'b000_0000_0010,
    ST_SQ_IM   = 11'b000_0000_0100,
    ST_ADD     = 11'b000_0000_1000,
    ST_ROOT    = 11'b000_0001_0000,
    ST_NORM_LD = 11'b000_0010_0000,
    ST_NORM    = 11'b000_0100_0000,
    ST_LOG     = 11'b000_1000_0000,
    ST_DB_MUL  = 11'b001_0000_0000,
    ST_DB_RND  = 11'b010_0000_0000,
    ST_EMIT    = 11'b100_0000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_SQ_RE;
        end
      end
      ST_SQ_RE: begin
        cmd.mul_re = 1'b1;
        state_nxt  = ST_SQ_IM;
      end
      ST_SQ_IM: begin
        cmd.mul_im = 1'b1;
        state_nxt  = ST_ADD;
      end
      ST_ADD: begin
        cmd.rad_ld = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_STEPS - 1)) begin
          state_nxt = sts.db_mode ? ST_NORM_LD : ST_EMIT;
        end
      end
      ST_NORM_LD: begin
        cmd.norm_ld = 1'b1;
        state_nxt   = ST_NORM;
      end
      ST_NORM: begin
        if (sts.norm_top) begin
          cnt_nxt   = '0;
          state_nxt = ST_LOG;
        end else begin
          cmd.norm_shift = 1'b1;
        end
      end
      ST_LOG: begin
        cnt_nxt = cnt_r + 1'b1;
        // first squaring has no fraction bit yet, the last only collects one
        if (cnt_r == '0) begin
          cmd.sq_mul   = 1'b1;
          cmd.sq_first = 1'b1;
        end else if (cnt_r == CNT_W'(LOG_BITS)) begin
          cmd.frac_shift = 1'b1;
          state_nxt      = ST_DB_MUL;
        end else begin
          cmd.sq_mul     = 1'b1;
          cmd.frac_shift = 1'b1;
        end
      end
      ST_DB_MUL: begin
        cmd.db_mul = 1'b1;
        state_nxt  = ST_DB_RND;
      end
      ST_DB_RND: begin
        cmd.db_rnd = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result loaded into a full output register");

  a_norm_db: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NORM) |-> sts.db_mode)
    else $error("log path entered in linear mode");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat taken while an item is in flight");
`endif

endmodule

`default_nettype wire

// ===== hdl/sbm_datapath.sv =====
`default_nettype none

module sbm_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sbm_pkg::sbm_cmd_t                 cmd,
  output sbm_pkg::sbm_sts_t                 sts,
  input  logic signed [sbm_pkg::COMP_W-1:0] re_part,
  input  logic signed [sbm_pkg::COMP_W-1:0] im_part,
  input  logic                              frame_end,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  sbm_out_if.source                         out_res
);
  import sbm_pkg::*;

  function automatic logic [COMP_W-1:0] abs_val(input logic [COMP_W-1:0] v);
    abs_val = v[COMP_W-1] ? (~v + 1'b1) : v;
  endfunction

  logic                db_mode_r;
  logic [COMP_W-1:0]   abs_re_r, abs_im_r;
  logic                last_r;
  logic [SQ_W-1:0]     mul_r, acc_r;
  logic [RAD_W-1:0]    rad_r;
  logic [REM_W-1:0]    rem_r;
  logic [MAG_W-1:0]    root_r;
  logic [NORM_W-1:0]   norm_r;
  logic [EXP_W-1:0]    exp_r;
  logic [LPROD_W-1:0]  prod_r;
  logic [LOG_BITS-1:0] frac_r;
  logic [DBPROD_W-1:0] dbprod_r;
  logic [MAG_W-1:0]    db_val_r;
  logic [MAG_W-1:0]    peak_r;
  logic [SUM_W-1:0]    sum_r;
  logic                out_valid_r;
  logic [MAG_W-1:0]    out_bin_r, out_peak_r;
  logic [SUM_W-1:0]    out_sum_r;
  logic                out_done_r;

  logic [COMP_W-1:0]   sq_op;
  logic [SQ_W-1:0]     sq_prod;
  logic [REM_W-1:0]    rem_sh, trial;
  logic [REM_W-1:0]    rem_nxt;
  logic [MAG_W-1:0]    root_nxt;
  logic [MANT_W-1:0]   log_in;
  logic [LPROD_W-1:0]  log_prod;
  logic [LOG_W-1:0]    log_val;
  logic [DBPROD_W-1:0] db_prod;
  logic [DBPROD_W:0]   db_rounded;
  logic [MAG_W-1:0]    bin_val;
  logic [MAG_W-1:0]    peak_nxt;
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W-1:0]    sum_nxt;

  // shared squarer for the two components
  assign sq_op   = cmd.mul_im ? abs_im_r : abs_re_r;
  assign sq_prod = sq_op * sq_op;

  // restoring square root, one result bit per beat of the sequencer
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_comb begin
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_r[MAG_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_r[MAG_W-2:0], 1'b0};
    end
  end

  // log2 fraction by repeated squaring of the Q1.30 mantissa
  assign log_in   = cmd.sq_first ? norm_r[NORM_W-1 -: MANT_W] :
                    (prod_r[LPROD_W-1] ? prod_r[LPROD_W-1 -: MANT_W]
                                       : prod_r[LPROD_W-2 -: MANT_W]);
  assign log_prod = log_in * log_in;

  assign log_val    = {LOGI_W'(exp_r - EXP_BIAS), frac_r};
  assign db_prod    = log_val * DB_PER_OCTAVE;
  assign db_rounded = {1'b0, dbprod_r} + DB_ROUND;

  // frame statistics
  assign bin_val  = db_mode_r ? db_val_r : root_r;
  assign peak_nxt = (bin_val > peak_r) ? bin_val : peak_r;
  assign sum_wide = {1'b0, sum_r} + {{(SUM_W + 1 - MAG_W){1'b0}}, bin_val};
  assign sum_nxt  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

  assign sts.out_free = !out_valid_r || out_res.ready;
  assign sts.db_mode  = db_mode_r;
  assign sts.norm_top = norm_r[NORM_W-1];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      abs_re_r <= abs_val(re_part);
      abs_im_r <= abs_val(im_part);
      last_r   <= frame_end;
    end
    if (cmd.mul_re) begin
      mul_r <= sq_prod;
    end
    if (cmd.mul_im) begin
      acc_r <= mul_r;
      mul_r <= sq_prod;
    end
    if (cmd.rad_ld) begin
      rad_r  <= {acc_r + mul_r, {(RAD_W - SQ_W){1'b0}}};
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.root_step) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
    if (cmd.norm_ld) begin
      norm_r <= {1'b0, root_r} + ONE_Q8;
      exp_r  <= EXP_TOP;
    end
    if (cmd.norm_shift) begin
      norm_r <= {norm_r[NORM_W-2:0], 1'b0};
      exp_r  <= exp_r - 1'b1;
    end
    if (cmd.sq_mul) begin
      prod_r <= log_prod;
    end
    if (cmd.sq_first) begin
      frac_r <= '0;
    end else if (cmd.frac_shift) begin
      frac_r <= {frac_r[LOG_BITS-2:0], prod_r[LPROD_W-1]};
    end
    if (cmd.db_mul) begin
      dbprod_r <= db_prod;
    end
    if (cmd.db_rnd) begin
      db_val_r <= MAG_W'(db_rounded[DBPROD_W:36]);
    end
    if (cmd.emit) begin
      out_bin_r  <= bin_val;
      out_peak_r <= peak_nxt;
      out_sum_r  <= sum_nxt;
      out_done_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_mode_r   <= 1'b0;
      peak_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        db_mode_r <= cfg_wdata;
      end
      if (cmd.emit) begin
        // statistics restart after the closing bin
        peak_r      <= last_r ? '0 : peak_nxt;
        sum_r       <= last_r ? '0 : sum_nxt;
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.bin_value  = out_bin_r;
  assign out_res.peak_value = out_peak_r;
  assign out_res.value_sum  = out_sum_r;
  assign out_res.frame_done = out_done_r;

`ifndef NO_ASSERTIONS
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("loaded result not presented");

  a_peak_ge_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_peak_r >= out_bin_r))
    else $error("peak below its own bin");

  a_sum_ge_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_sum_r >= {{(SUM_W - MAG_W){1'b0}}, out_peak_r}))
    else $error("frame sum below frame peak");
`endif

endmodule

`default_nettype wire

// ===== hdl/spectrum_bin_magnitude.sv =====
// Spectrum bin magnitude with per-frame peak and sum.
// in_bin: one complex bin per beat (signed re_part, im_part, frame_end flag).
// out_res: one result per bin: bin_value (magnitude, or 20*log10(1+mag) when
//   db_mode is set, both Q24.8), running frame peak, saturating frame sum
//   (Q36.8) and frame_done. Peak and sum restart after the frame_end bin.
// cfg_we/cfg_wdata write db_mode; write only while no bin is in flight.
// One bin at a time: the next beat can be taken in the cycle after the result
//   is loaded. The time a bin takes is set by the 32-step square root, the
//   one-bit-a-cycle normaliser and the 20 squarings of the log unit.
// The result sits in an output register; a stalled receiver holds it and
//   a new bin is still accepted and worked on, waiting only to be loaded.
// Reset (rst_n low, synchronous) clears db_mode, peak, sum and out valid.
`default_nettype none

module spectrum_bin_magnitude (
  input  logic      clk,
  input  logic      rst_n,
  sbm_in_if.sink    in_bin,
  sbm_out_if.source out_res,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);
  import sbm_pkg::*;

  sbm_cmd_t cmd;
  sbm_sts_t sts;
  logic     in_ready;

  sbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bin.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .re_part   (in_bin.re_part),
    .im_part   (in_bin.im_part),
    .frame_end (in_bin.frame_end),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_res   (out_res)
  );

  assign in_bin.ready = in_ready;

endmodule

`default_nettype wire
